// ===== hw/rtl/urh_pkg.sv =====
// Package for the unary run header block.
// Holds the beat types, command and status codes, and the job type shared by the front,
// the queue and the back end. Depends on nothing.
package urh_pkg;

    localparam int WORD_BITS   = 64;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] quotient;
    } t_in_beat;

    typedef struct packed {
        t_pos       run_start;
        t_pos       run_end;
        logic       nonempty;
        logic [1:0] status;
    } t_out_beat;

    // A classified request: decoded operation and the quotient after saturation.
    typedef struct packed {
        t_op  op;
        t_pos quotient;
    } t_job;

endpackage

// ===== hw/rtl/urh_front.sv =====
// Front end of the unary run header: accepts request beats and classifies them.
// Depends on urh_pkg for the beat, command and job types.
module urh_front #(
    parameter int QUOTIENTS = 32
) (
    input  logic              i_in_valid,
    input  urh_pkg::t_in_beat i_in_data,
    input  logic              i_full,
    output logic              o_in_stall,
    output logic              o_push,
    output urh_pkg::t_job     o_job
);

    urh_pkg::t_pos q_ext;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        q_ext = {1'b0, i_in_data.quotient};
        // A quotient beyond the last run addresses the last run.
        if (q_ext >= urh_pkg::t_pos'(QUOTIENTS)) begin
            o_job.quotient = urh_pkg::t_pos'(QUOTIENTS - 1);
        end else begin
            o_job.quotient = q_ext;
        end
        case (i_in_data.command)
            urh_pkg::CMD_LOOKUP: o_job.op = urh_pkg::OP_LOOKUP;
            urh_pkg::CMD_INSERT: o_job.op = urh_pkg::OP_INSERT;
            urh_pkg::CMD_REMOVE: o_job.op = urh_pkg::OP_REMOVE;
            default:             o_job.op = urh_pkg::OP_LOOKUP;
        endcase
    end

endmodule

// ===== hw/rtl/urh_queue.sv =====
// Short job queue between the front and the back end of the unary run header.
// Depends on urh_pkg for the job type and the queue depth.
module urh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  urh_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output urh_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(urh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(urh_pkg::QUEUE_DEPTH + 1);

    urh_pkg::t_job r_mem [urh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(urh_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

// ===== hw/rtl/urh_back.sv =====
// Back end of the unary run header: holds the header word, scans for a run one bit per
// cycle, applies insert or remove and registers the result beat. Depends on urh_pkg.
module urh_back #(
    parameter int QUOTIENTS = 32,
    parameter int CAPACITY  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  urh_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output urh_pkg::t_out_beat o_out_data
);

    // Every run must keep its closing zero inside the word.
    localparam int LIMIT = (CAPACITY < urh_pkg::WORD_BITS - QUOTIENTS) ?
                           CAPACITY : urh_pkg::WORD_BITS - QUOTIENTS;
    localparam urh_pkg::t_pos LAST_POS = urh_pkg::t_pos'(urh_pkg::WORD_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_END,
        S_EXEC
    } t_state;

    t_state                        r_state;
    logic [urh_pkg::WORD_BITS-1:0] r_bits;
    urh_pkg::t_pos                 r_fill;
    urh_pkg::t_op                  r_op;
    urh_pkg::t_pos                 r_q;
    urh_pkg::t_pos                 r_pos;
    urh_pkg::t_pos                 r_zeros;
    urh_pkg::t_pos                 r_start;
    logic                          r_out_valid;
    urh_pkg::t_out_beat            r_out;

    logic [urh_pkg::WORD_BITS-1:0] low_mask;
    logic [urh_pkg::WORD_BITS-1:0] ins_bits;
    logic [urh_pkg::WORD_BITS-1:0] rem_bits;
    urh_pkg::t_pos                 zeros_next;
    logic                          cur_bit;
    logic [urh_pkg::WORD_BITS-1:0] n_bits;
    urh_pkg::t_pos                 n_fill;
    urh_pkg::t_pos                 n_end;
    logic [1:0]                    n_status;

    assign o_pop       = (r_state == S_IDLE) && i_job_valid && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        cur_bit    = r_bits[r_pos];
        zeros_next = urh_pkg::t_pos'(r_zeros + 1'b1);
        low_mask   = (urh_pkg::WORD_BITS'(1) << r_start) - urh_pkg::WORD_BITS'(1);
        ins_bits   = (r_bits & low_mask) | (urh_pkg::WORD_BITS'(1) << r_start)
                   | ((r_bits & ~low_mask) << 1);
        rem_bits   = (r_bits & low_mask) | ((r_bits >> 1) & ~low_mask);

        // Outcome of the operation once the run is known.
        n_bits   = r_bits;
        n_fill   = r_fill;
        n_end    = r_pos;
        n_status = urh_pkg::STATUS_OK;
        case (r_op)
            urh_pkg::OP_INSERT: begin
                if (r_fill >= urh_pkg::t_pos'(LIMIT)) begin
                    n_status = urh_pkg::STATUS_FULL;
                end else begin
                    n_bits = ins_bits;
                    n_fill = urh_pkg::t_pos'(r_fill + 1'b1);
                    n_end  = urh_pkg::t_pos'(r_pos + 1'b1);
                end
            end
            urh_pkg::OP_REMOVE: begin
                if (r_start >= r_pos) begin
                    n_status = urh_pkg::STATUS_EMPTY;
                end else begin
                    n_bits = rem_bits;
                    n_fill = urh_pkg::t_pos'(r_fill - 1'b1);
                    n_end  = urh_pkg::t_pos'(r_pos - 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bits      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result is only made while the output register is empty.
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_op    <= i_job.op;
                        r_q     <= i_job.quotient;
                        r_zeros <= '0;
                        r_pos   <= '0;
                        if (i_job.quotient == '0) begin
                            r_start <= '0;
                            r_state <= S_END;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    // Count zeros until the one that closes the previous run.
                    if (!cur_bit && zeros_next == r_q) begin
                        if (r_pos == LAST_POS) begin
                            r_start <= LAST_POS;
                            r_pos   <= LAST_POS;
                        end else begin
                            r_start <= urh_pkg::t_pos'(r_pos + 1'b1);
                            r_pos   <= urh_pkg::t_pos'(r_pos + 1'b1);
                        end
                        r_state <= S_END;
                    end else begin
                        if (!cur_bit) begin
                            r_zeros <= zeros_next;
                        end
                        if (r_pos == LAST_POS) begin
                            r_start <= LAST_POS;
                            r_state <= S_END;
                        end else begin
                            r_pos <= urh_pkg::t_pos'(r_pos + 1'b1);
                        end
                    end
                end
                S_END: begin
                    // The run ends at its first zero, or at the top bit if none.
                    if (!cur_bit || r_pos == LAST_POS) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_pos <= urh_pkg::t_pos'(r_pos + 1'b1);
                    end
                end
                S_EXEC: begin
                    r_bits          <= n_bits;
                    r_fill          <= n_fill;
                    r_out.run_start <= r_start;
                    r_out.run_end   <= n_end;
                    r_out.nonempty  <= (r_start != n_end);
                    r_out.status    <= n_status;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/unary_run_header.sv =====
// Top level of the unary run header of a pocket-dictionary filter.
// Instantiates urh_front, urh_queue and urh_back; types come from urh_pkg.
//
//   channel   direction  handshake                 beat
//   request   in         i_in_valid / o_in_stall   urh_pkg::t_in_beat  (command, quotient)
//   result    out        o_out_valid / i_out_stall urh_pkg::t_out_beat (start, end, flags)
//
// After a request is accepted, it leaves the queue, the back end scans the header bits up to
// and including the zero that closes the run, and the change is applied as the result is
// registered. The scan walks the 64-bit word one bit per cycle.
// A synchronous reset empties the header and the queue at once; there is no clearing pass.
// The back end takes the next job only once the result has left the output register, so
// it does not start on a request before it is through with the last one.
// A stalled result holds in the output register while the front keeps taking requests
// into the two-entry queue until it fills.
module unary_run_header #(
    parameter int QUOTIENTS = 32,
    parameter int CAPACITY  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  urh_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output urh_pkg::t_out_beat o_out_data
);

    // Front to queue.
    logic          push;
    urh_pkg::t_job push_job;
    logic          queue_full;

    // Queue to back end.
    logic          job_valid;
    urh_pkg::t_job job;
    logic          pop;

    // The front decodes the command (the unused code acts as a lookup) and saturates the
    // quotient to the last run, so the back end only ever sees legal jobs.
    urh_front #(
        .QUOTIENTS (QUOTIENTS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (queue_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The queue decouples request acceptance from the multi-cycle scan.
    urh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (job_valid),
        .o_job   (job)
    );

    // The back end owns the header word and the fill count. It takes a new job only once
    // the previous result has left the output register.
    urh_back #(
        .QUOTIENTS (QUOTIENTS),
        .CAPACITY  (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/urh_checker.sv =====
// Port-level checker for the unary run header, bound to the top level.
// Depends on urh_pkg for the result beat type and status codes.
module urh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input urh_pkg::t_out_beat o_out_data
);

    // A result beat held back by the receiver stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat withdrawn while stalled");

    // The nonempty flag always agrees with the reported interval.
    a_nonempty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.nonempty == (o_out_data.run_start != o_out_data.run_end)))
        else $error("nonempty flag disagrees with run interval");

    // A refused remove reports an empty run.
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == urh_pkg::STATUS_EMPTY) |->
            (!o_out_data.nonempty && o_out_data.run_start == o_out_data.run_end))
        else $error("remove refused on a nonempty run");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat offered right after reset");

endmodule

bind unary_run_header urh_checker u_urh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== dv/urh_run_checker.sv =====
`timescale 1ns / 1ps
// Checker for unary_run_header: watches both channels, predicts each result beat from the
// request beats it sees, and compares. Depends on urh_pkg.
module urh_run_checker #(
    parameter int QUOTIENTS = 32,
    parameter int CAPACITY  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  urh_pkg::t_in_beat   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  urh_pkg::t_out_beat  i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Every run must keep its closing zero inside the word.
    localparam int FILL_LIMIT = (64 - QUOTIENTS < CAPACITY) ? 64 - QUOTIENTS : CAPACITY;

    logic [63:0]        header_word  = '0;
    logic [5:0]         stored_count = '0;
    urh_pkg::t_out_beat expected_runs[$];
    int                 mismatch_count = 0;
    int                 result_count   = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Applies one request to the predicted header and returns the result it causes.
    function automatic urh_pkg::t_out_beat apply_header_op(input urh_pkg::t_in_beat beat);
        urh_pkg::t_out_beat res;
        logic [63:0]        below;
        logic [1:0]         status;
        int                 q;
        int                 zeros;
        int                 first;
        int                 last;

        q = beat.quotient;
        if (q >= QUOTIENTS) begin
            q = QUOTIENTS - 1;
        end
        status = urh_pkg::STATUS_OK;

        // The run of quotient q starts just past the q-th zero of the word.
        first = (q == 0) ? 0 : 63;
        zeros = 0;
        if (q != 0) begin
            for (int i = 0; i < 64; i++) begin
                if (!header_word[i]) begin
                    zeros++;
                    if (zeros == q) begin
                        first = i + 1;
                        break;
                    end
                end
            end
        end
        if (first > 63) begin
            first = 63;
        end
        last = 63;
        for (int i = first; i < 64; i++) begin
            if (!header_word[i]) begin
                last = i;
                break;
            end
        end
        below = (64'd1 << first) - 64'd1;

        case (beat.command)
            urh_pkg::CMD_INSERT: begin
                if (stored_count >= FILL_LIMIT) begin
                    status = urh_pkg::STATUS_FULL;
                end else begin
                    header_word = (header_word & below) | (64'd1 << first)
                                | ((header_word & ~below) << 1);
                    stored_count = stored_count + 6'd1;
                    last = (last + 1) % 64;
                end
            end
            urh_pkg::CMD_REMOVE: begin
                if (first >= last) begin
                    status = urh_pkg::STATUS_EMPTY;
                end else begin
                    header_word = (header_word & below) | ((header_word >> 1) & ~below);
                    stored_count = stored_count - 6'd1;
                    last = last - 1;
                end
            end
            default: begin
                // Lookup, and the unused code which behaves as one.
            end
        endcase

        res.run_start = urh_pkg::t_pos'(first);
        res.run_end   = urh_pkg::t_pos'(last);
        res.nonempty  = (first != last);
        res.status    = status;
        return res;
    endfunction

    always @(posedge i_clk) begin
        urh_pkg::t_out_beat want;
        if (i_rst_n) begin
            // Compare before predicting, so a result can never match a request of this edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want = expected_runs.pop_front();
                    if (i_out_data.run_start !== want.run_start) begin
                        report_mismatch($sformatf("beat %0d run_start got %0d want %0d",
                            result_count, i_out_data.run_start, want.run_start));
                    end
                    if (i_out_data.run_end !== want.run_end) begin
                        report_mismatch($sformatf("beat %0d run_end got %0d want %0d",
                            result_count, i_out_data.run_end, want.run_end));
                    end
                    if (i_out_data.nonempty !== want.nonempty) begin
                        report_mismatch($sformatf("beat %0d nonempty got %b want %b",
                            result_count, i_out_data.nonempty, want.nonempty));
                    end
                    if (i_out_data.status !== want.status) begin
                        report_mismatch($sformatf("beat %0d status got %0d want %0d",
                            result_count, i_out_data.status, want.status));
                    end
                end
                result_count++;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_runs = {expected_runs, apply_header_op(i_in_data)};
            end
        end
        o_pending    <= expected_runs.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== dv/unary_run_header_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for unary_run_header: makes request beats, drives stall on the result side
// and gives the verdict. Depends on urh_pkg, unary_run_header and urh_run_checker.
module unary_run_header_tb;

    localparam int QUOTIENTS = 32;
    localparam int CAPACITY  = 32;

    // The two-bit command field has one code the block does not define; it acts as a lookup.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The watchdog limit is taken well above both the time the back end needs for one request
    // and the long hold-off below, so a correct run never reaches it without a beat on either
    // channel.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int BLOCK_ITEMS     = 250;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    urh_pkg::t_in_beat  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    urh_pkg::t_out_beat out_data;
    int                 fail_count;
    int                 pending;

    // Idling of both sides, in percent of cycles, set per phase by the stimulus.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Set by the stimulus to ask the receiver for one long stretch of stall.
    int hold_off_len  = 0;

    unary_run_header #(
        .QUOTIENTS(QUOTIENTS),
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    urh_run_checker #(
        .QUOTIENTS(QUOTIENTS),
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one request beat and returns at the edge that accepts it. Any idle gap comes
    // first, so valid is lowered and raised in different time steps, and valid stays high
    // from one beat to the next when there is no gap.
    task automatic send_beat(input logic [1:0] command, input logic [4:0] quotient);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid         <= 1'b1;
        in_data.command  <= command;
        in_data.quotient <= quotient;
        do @(posedge clk); while (in_stall);
    endtask

    // The first and last runs are the edges of the header word, so they get extra weight.
    function automatic logic [4:0] pick_quotient();
        case ($urandom_range(9))
            0:       return 5'd0;
            1:       return 5'd31;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    // A block of random requests. An insert-heavy mix drives the header to full and keeps
    // hitting the full case; a remove-heavy mix drains it and hits empty runs. A small share
    // of beats carries the unused command code.
    task automatic random_block(input int count, input int insert_pct, input int remove_pct);
        logic [1:0] op;
        int         roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                op = CMD_UNUSED;
            end else if (roll < 5 + insert_pct) begin
                op = urh_pkg::CMD_INSERT;
            end else if (roll < 5 + insert_pct + remove_pct) begin
                op = urh_pkg::CMD_REMOVE;
            end else begin
                op = urh_pkg::CMD_LOOKUP;
            end
            send_beat(op, pick_quotient());
        end
    endtask

    // Result side. A hold-off request from the stimulus takes priority; otherwise stall is
    // drawn fresh every cycle at the phase's rate.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int send_modes[4];
        int stall_modes[4];
        send_modes  = '{0, 72, 0, 33};
        stall_modes = '{0, 0, 72, 33};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on an empty header: the edge runs, the unused command, removes from
        // empty runs, a run grown and drained back past empty, and a few mid-word runs.
        send_beat(urh_pkg::CMD_LOOKUP, 5'd0);
        send_beat(urh_pkg::CMD_LOOKUP, 5'd31);
        send_beat(CMD_UNUSED, 5'd31);
        send_beat(urh_pkg::CMD_REMOVE, 5'd0);
        send_beat(urh_pkg::CMD_REMOVE, 5'd31);
        send_beat(urh_pkg::CMD_INSERT, 5'd0);
        send_beat(urh_pkg::CMD_INSERT, 5'd0);
        send_beat(urh_pkg::CMD_INSERT, 5'd31);
        send_beat(urh_pkg::CMD_INSERT, 5'd16);
        send_beat(urh_pkg::CMD_LOOKUP, 5'd0);
        send_beat(urh_pkg::CMD_LOOKUP, 5'd16);
        send_beat(CMD_UNUSED, 5'd16);
        send_beat(urh_pkg::CMD_REMOVE, 5'd0);
        send_beat(urh_pkg::CMD_REMOVE, 5'd0);
        send_beat(urh_pkg::CMD_REMOVE, 5'd0);
        send_beat(urh_pkg::CMD_INSERT, 5'd31);
        send_beat(urh_pkg::CMD_INSERT, 5'd31);
        send_beat(urh_pkg::CMD_REMOVE, 5'd31);
        send_beat(urh_pkg::CMD_LOOKUP, 5'd31);
        send_beat(urh_pkg::CMD_INSERT, 5'd21);
        send_beat(urh_pkg::CMD_INSERT, 5'd10);
        send_beat(urh_pkg::CMD_REMOVE, 5'd21);
        send_beat(urh_pkg::CMD_LOOKUP, 5'd10);
        send_beat(CMD_UNUSED, 5'd0);

        // Random part, once per idling phase. In the first phase the receiver holds off for
        // a long stretch while the sender keeps offering beats without gaps, so the queue and
        // the output register fill and the block stalls its input.
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = send_modes[mode];
            stall_pct     = stall_modes[mode];
            if (mode == 0) begin
                hold_off_len = HOLD_OFF_CYCLES;
                random_block(40, 60, 20);
            end
            random_block(BLOCK_ITEMS, 70, 10);
            random_block(BLOCK_ITEMS, 10, 70);
        end

        in_valid  <= 1'b0;
        stall_pct = 0;

        // The pending count is registered, so it lags behind the last accepted beat.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
